// ===== rtl/resp3_frame_validator_top_assert.svh =====
// Assertion macros used by the frame validator top level.
`ifndef RESP3_FRAME_VALIDATOR_TOP_ASSERT_SVH
`define RESP3_FRAME_VALIDATOR_TOP_ASSERT_SVH

// Implication within the same cycle.
`define RESP3FV_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("resp3fv: implication check failed");

// Implication checked in the next cycle.
`define RESP3FV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("resp3fv: next-cycle check failed");

// Condition that must never be seen.
`define RESP3FV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("resp3fv: forbidden condition seen");

`endif

// ===== rtl/resp3fv_pkg.sv =====
// Shared types, constants and lexer functions of the RESP3 frame validator.
`timescale 1ns / 1ps
`default_nettype none
package resp3fv_pkg;

  localparam int MAX_NEST  = 8;
  localparam int NEST_W    = $clog2(MAX_NEST + 1);
  localparam int IDX_W     = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NESTING = 4'd1;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd536870912;
  localparam logic [3:0]  MAX_NESTING_RST = 4'd8;

  localparam logic [47:0] SAT48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MUL_LIMIT = 64'd922337203685477580;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;

  // Type bytes.
  localparam logic [7:0] K_SIMPLE = 8'h2B;
  localparam logic [7:0] K_ERROR  = 8'h2D;
  localparam logic [7:0] K_INT    = 8'h3A;
  localparam logic [7:0] K_BULK   = 8'h24;
  localparam logic [7:0] K_ARRAY  = 8'h2A;
  localparam logic [7:0] K_NULL   = 8'h5F;
  localparam logic [7:0] K_BOOL   = 8'h23;
  localparam logic [7:0] K_DOUBLE = 8'h2C;
  localparam logic [7:0] K_BIGNUM = 8'h28;
  localparam logic [7:0] K_BLOBER = 8'h21;
  localparam logic [7:0] K_VERBAT = 8'h3D;
  localparam logic [7:0] K_MAP    = 8'h25;
  localparam logic [7:0] K_SET    = 8'h7E;
  localparam logic [7:0] K_PUSH   = 8'h3E;
  localparam logic [7:0] K_ATTR   = 8'h7C;

  // Double lexer states.
  localparam logic [3:0] DS_START = 4'd0;
  localparam logic [3:0] DS_SIGN  = 4'd1;
  localparam logic [3:0] DS_INT   = 4'd2;
  localparam logic [3:0] DS_DOT   = 4'd3;
  localparam logic [3:0] DS_FRAC  = 4'd4;
  localparam logic [3:0] DS_EXP   = 4'd5;
  localparam logic [3:0] DS_ESIGN = 4'd6;
  localparam logic [3:0] DS_EDIG  = 4'd7;
  localparam logic [3:0] DS_BAD   = 4'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEED_MORE = 3'd1,
    ST_INT_ERR   = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_SIZE      = 3'd4,
    ST_DEPTH     = 3'd5,
    ST_UNKNOWN   = 3'd6
  } status_t;

  typedef struct packed {
    logic [63:0] value;
    logic        neg;
    logic        dig;
    logic        ibad;
    logic        ovf;
    logic        bdig;
    logic        bbad;
    logic [7:0]  len;
    logic [31:0] tail;
    logic [3:0]  dst;
  } lex_t;

  typedef struct packed {
    logic [63:0] left;
    logic [47:0] start;
  } stk_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    stk_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  kind;
    logic [47:0] length;
    logic [62:0] count;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic known_type(input logic [7:0] c);
    logic k;
    case (c)
      K_SIMPLE, K_ERROR, K_INT, K_BULK, K_ARRAY, K_NULL, K_BOOL, K_DOUBLE,
      K_BIGNUM, K_BLOBER, K_VERBAT, K_MAP, K_SET, K_PUSH, K_ATTR: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [47:0] sat_inc(input logic [47:0] v);
    return (v != SAT48) ? v + 48'd1 : v;
  endfunction

  function automatic logic [3:0] dbl_next(input logic [3:0] s, input logic [7:0] c);
    logic d;
    logic sg;
    logic e;
    logic [3:0] n;
    d  = is_digit(c);
    sg = (c == CH_PLUS) || (c == CH_MINUS);
    e  = (c == CH_E_LO) || (c == CH_E_UP);
    case (s)
      DS_START: n = sg ? DS_SIGN : d ? DS_INT : (c == CH_DOT) ? DS_DOT : DS_BAD;
      DS_SIGN:  n = d ? DS_INT : (c == CH_DOT) ? DS_DOT : DS_BAD;
      DS_INT:   n = d ? DS_INT : (c == CH_DOT) ? DS_FRAC : e ? DS_EXP : DS_BAD;
      DS_DOT:   n = d ? DS_FRAC : DS_BAD;
      DS_FRAC:  n = d ? DS_FRAC : e ? DS_EXP : DS_BAD;
      DS_EXP:   n = sg ? DS_ESIGN : d ? DS_EDIG : DS_BAD;
      DS_ESIGN: n = d ? DS_EDIG : DS_BAD;
      DS_EDIG:  n = d ? DS_EDIG : DS_BAD;
      default:  n = DS_BAD;
    endcase
    return n;
  endfunction

  // Fold one header byte into the running integer, big-number and double checks.
  function automatic lex_t lex_step(input lex_t s, input logic [7:0] c);
    lex_t n;
    logic d;
    logic pos0;
    n    = s;
    d    = is_digit(c);
    pos0 = (s.len == 8'd0);
    if (s.len != 8'hFF) n.len = s.len + 8'd1;
    n.tail = {s.tail[23:0], c};
    if (pos0 && (c == CH_MINUS)) begin
      n.neg = 1'b1;
    end else if (d) begin
      n.dig = 1'b1;
      if (!s.ovf) begin
        if (s.value > MUL_LIMIT) begin
          n.ovf = 1'b1;
        end else begin
          n.value = (s.value << 3) + (s.value << 1) + {60'd0, c[3:0]};
          if (n.value > TOP_BIT) n.ovf = 1'b1;
        end
      end
    end else begin
      n.ibad = 1'b1;
    end
    if (!(pos0 && ((c == CH_MINUS) || (c == CH_PLUS)))) begin
      if (d) n.bdig = 1'b1;
      else n.bbad = 1'b1;
    end
    n.dst = dbl_next(s.dst, c);
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/resp3_frame_validator_top.sv =====
// Top level of the RESP3 frame validator: byte lexer, nesting control, result queue.
// Throughput: one stream byte per cycle while in_ready is high; input stalls while the
//   result queue is full and while a byte's unwind reads the enclosing levels from the
//   stack memory through its registered read port. A result enters the result queue as
//   its byte is taken, or at the end of the unwind that byte starts.
// A two-word result queue lets input continue while a result waits.
// Reset (rst_n low, synchronous): restart at a type byte, empty stack and queue,
//   registers back to max_payload_bytes = 2^29 and max_nesting = 8.
`timescale 1ns / 1ps
`default_nettype none
`include "resp3_frame_validator_top_assert.svh"
module resp3_frame_validator_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_stream_byte,
  input  wire logic                              in_buffer_end,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_status,
  output logic [7:0]                             out_frame_kind,
  output logic [47:0]                            out_frame_length,
  output logic [62:0]                            out_child_count,
  input  wire logic                              cfg_we,
  input  wire logic [resp3fv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_wdata
);
  import resp3fv_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE, PH_HEADER, PH_PAYLOAD, PH_BULK_CR, PH_BULK_LF, PH_UNWIND
  } phase_t;

  // Control state.
  phase_t            phase_r, phase_nxt;
  logic [NEST_W-1:0] nest_r, nest_nxt;
  status_t           pending_r, pending_nxt;
  logic              cr_held_r, cr_held_nxt;
  logic              unw_end_r, unw_end_nxt;
  logic [1:0]        q_cnt_r;
  logic [31:0]       max_payload_r;
  logic [3:0]        max_nest_r;

  // Payload state.
  lex_t        lex_r, lex_nxt;
  logic [7:0]  cur_kind_r, cur_kind_nxt;
  logic [31:0] bulk_left_r, bulk_left_nxt;
  logic        bulk_cr_ok_r, bulk_cr_ok_nxt;
  logic [47:0] bytes_r, bytes_nxt;
  logic [47:0] elem_start_r, elem_start_nxt;
  logic [7:0]  top_kind_r, top_kind_nxt;
  logic [62:0] top_count_r, top_count_nxt;
  logic [63:0] top_left_r, top_left_nxt;
  logic [47:0] top_start_r, top_start_nxt;
  res_t        q0_r, q1_r;

  ram_req_t ram_req;
  stk_t     rd_data;
  res_t     res;
  logic     res_valid;
  logic     acc;
  logic     pop;

  // Header verdicts, taken from the lexer state that precedes the closing LF.
  logic        iv;
  logic        hneg;
  logic        mag_one;
  logic        dbl_ok;
  logic        bool_ok;
  logic        big_ok;
  logic [NEST_W-1:0] lim;
  logic [NEST_W-1:0] nest_m1;
  logic [NEST_W-1:0] nest_m2;

  assign iv = lex_r.dig && !lex_r.ibad && !lex_r.ovf &&
              (lex_r.neg ? (lex_r.value <= TOP_BIT) : (lex_r.value < TOP_BIT));
  assign hneg    = lex_r.neg && (lex_r.value != 64'd0);
  assign mag_one = (lex_r.value == 64'd1);
  assign bool_ok = (lex_r.len == 8'd1) &&
                   ((lex_r.tail[7:0] == CH_T) || (lex_r.tail[7:0] == CH_F));
  assign big_ok  = lex_r.bdig && !lex_r.bbad;
  assign dbl_ok  = ((lex_r.len == 8'd3) &&
                    ((lex_r.tail[23:0] == 24'h696E66) || (lex_r.tail[23:0] == 24'h6E616E))) ||
                   ((lex_r.len == 8'd4) &&
                    ((lex_r.tail == 32'h2B696E66) || (lex_r.tail == 32'h2D696E66))) ||
                   (lex_r.dst == DS_INT) || (lex_r.dst == DS_FRAC) || (lex_r.dst == DS_EDIG);

  assign nest_m1 = nest_r - NEST_W'(1);
  assign nest_m2 = nest_r - NEST_W'(2);

  always_comb begin
    if (int'(max_nest_r) < MAX_NEST) lim = NEST_W'(max_nest_r);
    else lim = NEST_W'(MAX_NEST);
  end

  // Hold input while the stack unwinds or the result queue is full.
  assign in_ready = (phase_r != PH_UNWIND) && (q_cnt_r != 2'd2);
  assign acc      = in_valid && in_ready;

  resp3fv_stack_ram u_stack (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  always_comb begin
    logic        hdr_done;
    logic        fin;
    logic        emit;
    status_t     emit_st;
    logic        end_eff;
    logic [47:0] base;
    logic [47:0] diff;
    logic [63:0] left;
    logic [31:0] bl;
    lex_t        lx;

    phase_nxt      = phase_r;
    nest_nxt       = nest_r;
    pending_nxt    = pending_r;
    cr_held_nxt    = cr_held_r;
    unw_end_nxt    = unw_end_r;
    lex_nxt        = lex_r;
    cur_kind_nxt   = cur_kind_r;
    bulk_left_nxt  = bulk_left_r;
    bulk_cr_ok_nxt = bulk_cr_ok_r;
    bytes_nxt      = bytes_r;
    elem_start_nxt = elem_start_r;
    top_kind_nxt   = top_kind_r;
    top_count_nxt  = top_count_r;
    top_left_nxt   = top_left_r;
    top_start_nxt  = top_start_r;
    ram_req        = '0;
    hdr_done       = 1'b0;
    fin            = 1'b0;
    emit           = 1'b0;
    emit_st        = ST_OK;
    base           = '0;
    diff           = '0;
    left           = '0;
    bl             = '0;
    lx             = lex_r;

    if (acc) begin
      if (phase_r == PH_TYPE) begin
        // A top-level type byte opens a new frame count.
        base = (nest_r == '0) ? 48'd0 : bytes_r;
        if (nest_r == '0) begin
          top_kind_nxt  = in_stream_byte;
          top_count_nxt = '0;
        end
        elem_start_nxt = base;
        bytes_nxt      = sat_inc(base);
        if (nest_r >= lim) begin
          emit    = 1'b1;
          emit_st = ST_DEPTH;
        end else begin
          cur_kind_nxt = in_stream_byte;
          pending_nxt  = known_type(in_stream_byte) ? ST_OK : ST_UNKNOWN;
          lex_nxt      = '0;
          cr_held_nxt  = (in_stream_byte == CH_CR);
          phase_nxt    = PH_HEADER;
        end
      end else begin
        bytes_nxt = sat_inc(bytes_r);
        case (phase_r)
          PH_HEADER: begin
            if (cr_held_r && (in_stream_byte == CH_LF)) begin
              cr_held_nxt = 1'b0;
              hdr_done    = 1'b1;
            end else begin
              // A held CR not followed by LF is ordinary header text.
              if (cr_held_r) lx = lex_step(lx, CH_CR);
              cr_held_nxt = (in_stream_byte == CH_CR);
              if (in_stream_byte != CH_CR) lx = lex_step(lx, in_stream_byte);
              lex_nxt = lx;
            end
          end
          PH_PAYLOAD: begin
            bl = bulk_left_r;
            if (bl != 32'd0) bl = bl - 32'd1;
            bulk_left_nxt = bl;
            if (bl == 32'd0) phase_nxt = PH_BULK_CR;
          end
          PH_BULK_CR: begin
            bulk_cr_ok_nxt = (in_stream_byte == CH_CR);
            phase_nxt      = PH_BULK_LF;
          end
          PH_BULK_LF: begin
            if (bulk_cr_ok_r && (in_stream_byte == CH_LF)) begin
              fin = 1'b1;
            end else begin
              emit    = 1'b1;
              emit_st = ST_MALFORMED;
            end
          end
          default: ;
        endcase
      end
    end

    // Header line complete: check its text against the element type.
    if (hdr_done) begin
      if (pending_r != ST_OK) begin
        emit    = 1'b1;
        emit_st = pending_r;
      end else begin
        case (cur_kind_r)
          K_INT: begin
            if (iv) fin = 1'b1;
            else begin emit = 1'b1; emit_st = ST_INT_ERR; end
          end
          K_BOOL: begin
            if (bool_ok) fin = 1'b1;
            else begin emit = 1'b1; emit_st = ST_MALFORMED; end
          end
          K_DOUBLE: begin
            if (dbl_ok) fin = 1'b1;
            else begin emit = 1'b1; emit_st = ST_MALFORMED; end
          end
          K_BIGNUM: begin
            if (big_ok) fin = 1'b1;
            else begin emit = 1'b1; emit_st = ST_MALFORMED; end
          end
          K_BULK, K_BLOBER, K_VERBAT: begin
            if (!iv) begin
              emit = 1'b1; emit_st = ST_INT_ERR;
            end else if (hneg && mag_one) begin
              fin = 1'b1;
            end else if (hneg) begin
              emit = 1'b1; emit_st = ST_INT_ERR;
            end else if (lex_r.value > {32'd0, max_payload_r}) begin
              emit = 1'b1; emit_st = ST_SIZE;
            end else begin
              bulk_left_nxt = lex_r.value[31:0];
              phase_nxt = (lex_r.value != 64'd0) ? PH_PAYLOAD : PH_BULK_CR;
            end
          end
          K_ARRAY, K_MAP, K_SET, K_PUSH, K_ATTR: begin
            if ((cur_kind_r == K_ARRAY) && iv && hneg && mag_one) begin
              fin = 1'b1;
            end else if (!iv || hneg) begin
              emit = 1'b1; emit_st = ST_MALFORMED;
            end else begin
              if (nest_r == '0) top_count_nxt = lex_r.value[62:0];
              // Maps and attributes count key and value separately.
              left = ((cur_kind_r == K_MAP) || (cur_kind_r == K_ATTR)) ?
                     {lex_r.value[62:0], 1'b0} : lex_r.value;
              if (left == 64'd0) begin
                fin = 1'b1;
              end else if (nest_r >= NEST_W'(MAX_NEST)) begin
                emit = 1'b1; emit_st = ST_DEPTH;
              end else begin
                // Push: spill the cached top level into the stack memory.
                if (nest_r != '0) begin
                  ram_req.we          = 1'b1;
                  ram_req.waddr       = nest_m1[IDX_W-1:0];
                  ram_req.wdata.left  = top_left_r;
                  ram_req.wdata.start = top_start_r;
                end
                top_left_nxt  = left;
                top_start_nxt = elem_start_r;
                nest_nxt      = nest_r + NEST_W'(1);
                phase_nxt     = PH_TYPE;
              end
            end
          end
          default: fin = 1'b1;
        endcase
      end
    end

    // Element done: count it against the cached enclosing aggregate.
    if (fin) begin
      if (nest_r == '0) begin
        emit = 1'b1; emit_st = ST_OK;
      end else begin
        diff = bytes_nxt - top_start_r;
        left = top_left_r - 64'd1;
        if (diff > {16'd0, max_payload_r}) begin
          emit = 1'b1; emit_st = ST_SIZE;
        end else if (left != 64'd0) begin
          top_left_nxt = left;
          phase_nxt    = PH_TYPE;
        end else begin
          nest_nxt = nest_m1;
          if (nest_m1 == '0) begin
            emit = 1'b1; emit_st = ST_OK;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = nest_m2[IDX_W-1:0];
            phase_nxt     = PH_UNWIND;
            unw_end_nxt   = in_buffer_end;
          end
        end
      end
    end

    // Unwind: the enclosing level arrives from the stack memory.
    if (phase_r == PH_UNWIND) begin
      diff = bytes_r - rd_data.start;
      left = rd_data.left - 64'd1;
      if (diff > {16'd0, max_payload_r}) begin
        emit = 1'b1; emit_st = ST_SIZE;
      end else if (left != 64'd0) begin
        top_left_nxt  = left;
        top_start_nxt = rd_data.start;
        phase_nxt     = PH_TYPE;
      end else begin
        nest_nxt = nest_m1;
        if (nest_m1 == '0) begin
          emit = 1'b1; emit_st = ST_OK;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = nest_m2[IDX_W-1:0];
        end
      end
    end

    end_eff = (phase_r == PH_UNWIND) ? unw_end_r : (acc && in_buffer_end);
    if (end_eff && !emit && (phase_nxt != PH_UNWIND)) begin
      emit    = 1'b1;
      emit_st = ST_NEED_MORE;
    end

    res_valid    = emit;
    res.status   = emit_st;
    res.kind     = top_kind_nxt;
    res.length   = (emit_st == ST_OK) ? bytes_nxt : 48'd0;
    res.count    = (emit_st == ST_OK) ? top_count_nxt : 63'd0;

    // Restart at a type byte after every result.
    if (emit) begin
      phase_nxt   = PH_TYPE;
      nest_nxt    = '0;
      pending_nxt = ST_OK;
      cr_held_nxt = 1'b0;
    end
  end

  assign pop = (q_cnt_r != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TYPE;
      nest_r        <= '0;
      pending_r     <= ST_OK;
      cr_held_r     <= 1'b0;
      unw_end_r     <= 1'b0;
      q_cnt_r       <= 2'd0;
      max_payload_r <= MAX_PAYLOAD_RST;
      max_nest_r    <= MAX_NESTING_RST;
    end else begin
      phase_r   <= phase_nxt;
      nest_r    <= nest_nxt;
      pending_r <= pending_nxt;
      cr_held_r <= cr_held_nxt;
      unw_end_r <= unw_end_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
          CFG_MAX_NESTING: max_nest_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      case ({pop, res_valid})
        2'b11: q_cnt_r <= q_cnt_r;
        2'b10: q_cnt_r <= q_cnt_r - 2'd1;
        2'b01: q_cnt_r <= q_cnt_r + 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
    lex_r        <= lex_nxt;
    cur_kind_r   <= cur_kind_nxt;
    bulk_left_r  <= bulk_left_nxt;
    bulk_cr_ok_r <= bulk_cr_ok_nxt;
    bytes_r      <= bytes_nxt;
    elem_start_r <= elem_start_nxt;
    top_kind_r   <= top_kind_nxt;
    top_count_r  <= top_count_nxt;
    top_left_r   <= top_left_nxt;
    top_start_r  <= top_start_nxt;
    // Result queue: advance the head on pop, append the new word behind it.
    case ({pop, res_valid})
      2'b11: begin
        if (q_cnt_r == 2'd1) q0_r <= res;
        else begin q0_r <= q1_r; q1_r <= res; end
      end
      2'b10: q0_r <= q1_r;
      2'b01: begin
        if (q_cnt_r == 2'd0) q0_r <= res;
        else q1_r <= res;
      end
      default: ;
    endcase
  end

  assign out_valid        = (q_cnt_r != 2'd0);
  assign out_status       = q0_r.status;
  assign out_frame_kind   = q0_r.kind;
  assign out_frame_length = q0_r.length;
  assign out_child_count  = q0_r.count;

  `RESP3FV_ASSERT_IMPL(a_unwind_nested, phase_r == PH_UNWIND, nest_r != '0)
  `RESP3FV_ASSERT_IMPL(a_err_zero, out_valid && (out_status != ST_OK),
                       (out_frame_length == 48'd0) && (out_child_count == 63'd0))
  `RESP3FV_ASSERT_NEVER(a_queue_bound, q_cnt_r == 2'd3)
  `RESP3FV_ASSERT_NEXT(a_result_restart, res_valid, (nest_r == '0) && (phase_r == PH_TYPE))

endmodule
`default_nettype wire

// ===== rtl/resp3fv_stack_ram.sv =====
// Nesting stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module resp3fv_stack_ram (
  input  wire logic                clk,
  input  wire resp3fv_pkg::ram_req_t req,
  output resp3fv_pkg::stk_t        rd_data
);
  import resp3fv_pkg::*;

  stk_t mem [MAX_NEST];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// ===== verif/resp3_frame_validator_top_test.sv =====
// Self-checking testbench for the RESP3 frame validator top level.
`timescale 1ns / 1ps
`default_nettype none
module resp3_frame_validator_top_test;
  import resp3fv_pkg::*;

  // Codes local to the bench: predictor phases and one unmapped register slot.
  typedef enum int {
    P_TYPE,
    P_HEADER,
    P_PAYLOAD,
    P_BULK_CR,
    P_BULK_LF
  } parse_phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } stream_word_t;

  typedef struct {
    status_t     st;
    logic [7:0]  kind;
    logic [47:0] len;
    logic [62:0] cnt;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_stream_byte;
  logic in_buffer_end;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic [7:0] out_frame_kind;
  logic [47:0] out_frame_length;
  logic [62:0] out_child_count;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  resp3_frame_validator_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_stream_byte(in_stream_byte),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_frame_kind(out_frame_kind),
    .out_frame_length(out_frame_length),
    .out_child_count(out_child_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Words waiting to be driven, and verdicts waiting to come out.
  stream_word_t pending_words[$];
  verdict_t     verdicts_due[$];
  logic [7:0]   frame_bytes[$];

  int errors = 0;
  int cycles = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Predictor state: the block's configuration and parser, tracked here.
  logic [31:0] lim_payload;
  logic [3:0]  lim_nest;
  parse_phase_t ph;
  logic [63:0] left_stk[MAX_NEST];
  logic [63:0] start_stk[MAX_NEST];
  int unsigned lvl;
  logic [63:0] hval;
  logic f_neg, f_dig, f_ibad, f_ovf, f_bdig, f_bbad;
  int unsigned hlen;
  logic [63:0] htail;
  logic [3:0]  dst;
  logic [63:0] bulk_left;
  logic [63:0] seen;
  status_t     held_err;
  logic [7:0]  top_k;
  logic [63:0] top_cnt;
  logic [7:0]  cur_kind;
  logic [63:0] elem_start;
  logic        cr_held;
  logic        bulk_cr_ok;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Close the frame with a verdict and restart at a type byte.
  function automatic bit close_frame(status_t st);
    verdict_t v;
    v.st   = st;
    v.kind = top_k;
    v.len  = (st == ST_OK) ? seen[47:0] : 48'd0;
    v.cnt  = (st == ST_OK) ? top_cnt[62:0] : 63'd0;
    verdicts_due.push_back(v);
    ph = P_TYPE;
    lvl = 0;
    held_err = ST_OK;
    cr_held = 1'b0;
    return 1'b1;
  endfunction

  // Pop finished aggregates; check each one's span as it loses a child.
  function automatic bit end_element();
    int unsigned p;
    while (lvl > 0) begin
      p = lvl - 1;
      left_stk[p] = left_stk[p] - 64'd1;
      if (seen - start_stk[p] > {32'd0, lim_payload}) return close_frame(ST_SIZE);
      if (left_stk[p] != 64'd0) begin
        ph = P_TYPE;
        return 1'b0;
      end
      lvl = p;
    end
    return close_frame(ST_OK);
  endfunction

  function automatic logic [3:0] float_next(logic [3:0] s, logic [7:0] c);
    logic d, sg, e;
    d  = (c >= CH_0) && (c <= CH_9);
    sg = (c == CH_PLUS) || (c == CH_MINUS);
    e  = (c == CH_E_LO) || (c == CH_E_UP);
    case (s)
      DS_START: return sg ? DS_SIGN : d ? DS_INT : (c == CH_DOT) ? DS_DOT : DS_BAD;
      DS_SIGN:  return d ? DS_INT : (c == CH_DOT) ? DS_DOT : DS_BAD;
      DS_INT:   return d ? DS_INT : (c == CH_DOT) ? DS_FRAC : e ? DS_EXP : DS_BAD;
      DS_DOT:   return d ? DS_FRAC : DS_BAD;
      DS_FRAC:  return d ? DS_FRAC : e ? DS_EXP : DS_BAD;
      DS_EXP:   return sg ? DS_ESIGN : d ? DS_EDIG : DS_BAD;
      DS_ESIGN: return d ? DS_EDIG : DS_BAD;
      DS_EDIG:  return d ? DS_EDIG : DS_BAD;
      default:  return DS_BAD;
    endcase
  endfunction

  // Fold one header byte into the integer, big-number and float trackers.
  function automatic void scan_header(logic [7:0] c);
    int unsigned pos;
    logic d;
    pos = hlen;
    d = (c >= CH_0) && (c <= CH_9);
    if (hlen < 255) hlen++;
    htail = {htail[55:0], c};
    if (pos == 0 && c == CH_MINUS) f_neg = 1'b1;
    else if (d) begin
      f_dig = 1'b1;
      if (!f_ovf) begin
        if (hval > MUL_LIMIT) f_ovf = 1'b1;
        else begin
          hval = hval * 64'd10 + {60'd0, c[3:0]};
          if (hval > TOP_BIT) f_ovf = 1'b1;
        end
      end
    end else f_ibad = 1'b1;
    if (!(pos == 0 && (c == CH_MINUS || c == CH_PLUS))) begin
      if (d) f_bdig = 1'b1;
      else f_bbad = 1'b1;
    end
    dst = float_next(dst, c);
  endfunction

  function automatic bit header_closed();
    bit iv, neg, fv;
    logic [63:0] lft;
    iv = f_dig && !f_ibad && !f_ovf && (f_neg ? hval <= TOP_BIT : hval < TOP_BIT);
    neg = f_neg && hval != 64'd0;
    fv = (hlen == 3 && (htail[23:0] == "inf" || htail[23:0] == "nan")) ||
         (hlen == 4 && (htail[31:0] == "+inf" || htail[31:0] == "-inf")) ||
         dst == DS_INT || dst == DS_FRAC || dst == DS_EDIG;
    if (held_err != ST_OK) return close_frame(held_err);
    case (cur_kind)
      K_INT: return iv ? end_element() : close_frame(ST_INT_ERR);
      K_BOOL: return (hlen == 1 && (htail[7:0] == CH_T || htail[7:0] == CH_F)) ?
                     end_element() : close_frame(ST_MALFORMED);
      K_DOUBLE: return fv ? end_element() : close_frame(ST_MALFORMED);
      K_BIGNUM: return (f_bdig && !f_bbad) ? end_element() : close_frame(ST_MALFORMED);
      K_BULK, K_BLOBER, K_VERBAT: begin
        if (!iv) return close_frame(ST_INT_ERR);
        if (neg && hval == 64'd1) return end_element();
        if (neg) return close_frame(ST_INT_ERR);
        if (hval > {32'd0, lim_payload}) return close_frame(ST_SIZE);
        bulk_left = hval;
        ph = (hval != 64'd0) ? P_PAYLOAD : P_BULK_CR;
        return 1'b0;
      end
      K_ARRAY, K_MAP, K_SET, K_PUSH, K_ATTR: begin
        if (cur_kind == K_ARRAY && iv && neg && hval == 64'd1) return end_element();
        if (!iv || neg) return close_frame(ST_MALFORMED);
        if (lvl == 0) top_cnt = hval;
        lft = (cur_kind == K_MAP || cur_kind == K_ATTR) ? hval * 64'd2 : hval;
        if (lft == 64'd0) return end_element();
        if (lvl >= MAX_NEST) return close_frame(ST_DEPTH);
        left_stk[lvl] = lft;
        start_stk[lvl] = elem_start;
        lvl++;
        ph = P_TYPE;
        return 1'b0;
      end
      default: return end_element();
    endcase
  endfunction

  // Advance the parser by one accepted word; queue any verdict it causes.
  function automatic void parse_word(logic [7:0] b, logic e);
    bit r;
    int unsigned lim;
    r = 1'b0;
    if (ph == P_TYPE) begin
      lim = (lim_nest < MAX_NEST) ? lim_nest : MAX_NEST;
      if (lvl == 0) begin
        seen = 64'd0;
        top_k = b;
        top_cnt = 64'd0;
      end
      elem_start = seen;
      if (seen < {16'd0, SAT48}) seen++;
      if (lvl >= lim) begin
        void'(close_frame(ST_DEPTH));
        return;
      end
      cur_kind = b;
      case (b)
        K_SIMPLE, K_ERROR, K_INT, K_BULK, K_ARRAY, K_NULL, K_BOOL, K_DOUBLE,
        K_BIGNUM, K_BLOBER, K_VERBAT, K_MAP, K_SET, K_PUSH, K_ATTR: held_err = ST_OK;
        default: held_err = ST_UNKNOWN;
      endcase
      hval = 64'd0;
      {f_neg, f_dig, f_ibad, f_ovf, f_bdig, f_bbad} = 6'd0;
      hlen = 0;
      htail = 64'd0;
      dst = DS_START;
      cr_held = (b == CH_CR);
      ph = P_HEADER;
    end else begin
      if (seen < {16'd0, SAT48}) seen++;
      case (ph)
        P_HEADER: begin
          if (cr_held && b == CH_LF) begin
            cr_held = 1'b0;
            r = header_closed();
          end else begin
            if (cr_held) scan_header(CH_CR);
            cr_held = (b == CH_CR);
            if (!cr_held) scan_header(b);
          end
        end
        P_PAYLOAD: begin
          if (bulk_left != 64'd0) bulk_left--;
          if (bulk_left == 64'd0) ph = P_BULK_CR;
        end
        P_BULK_CR: begin
          bulk_cr_ok = (b == CH_CR);
          ph = P_BULK_LF;
        end
        default: r = (bulk_cr_ok && b == CH_LF) ? end_element() : close_frame(ST_MALFORMED);
      endcase
    end
    if (!r && e) void'(close_frame(ST_NEED_MORE));
  endfunction

  // Sender: hold the word until taken, then offer the next one or idle.
  always @(posedge clk) begin
    stream_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_in_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_stream_byte <= w.b;
        in_buffer_end <= w.e;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
    end
  end

  // Monitor: predict on every accepted word, compare every delivered verdict.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (in_valid && in_ready) parse_word(in_stream_byte, in_buffer_end);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict status %0d kind %h", $time, out_status,
                   out_frame_kind);
        end else begin
          v = verdicts_due.pop_front();
          if (out_status !== v.st) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, v.st, out_status);
          end
          if (out_frame_kind !== v.kind) begin
            errors++;
            $display("%0t: frame_kind exp %h got %h", $time, v.kind, out_frame_kind);
          end
          if (out_frame_length !== v.len) begin
            errors++;
            $display("%0t: frame_length exp %0d got %0d", $time, v.len, out_frame_length);
          end
          if (out_child_count !== v.cnt) begin
            errors++;
            $display("%0t: child_count exp %0d got %0d", $time, v.cnt, out_child_count);
          end
        end
      end
    end
  end

  // Watchdog: end the run as a mismatch once the cycle counter passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("resp3_frame_validator_top: mismatch");
      $finish;
    end
  end

  // Append text; '^' stands for CR LF.
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "^") begin
        frame_bytes.push_back(CH_CR);
        frame_bytes.push_back(CH_LF);
      end else begin
        frame_bytes.push_back(s[i]);
      end
    end
  endtask

  // Queue the built frame; usually mark its last byte as the buffer end.
  task automatic queue_frame(int end_pct);
    stream_word_t w;
    int cut;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      w.b = frame_bytes[i];
      w.e = (i == cut) ||
            (i == frame_bytes.size() - 1 && $urandom_range(0, 99) < end_pct);
      pending_words.push_back(w);
    end
    frame_bytes.delete();
  endtask

  function automatic string int_text();
    case ($urandom_range(0, 9))
      0: return "9223372036854775807";
      1: return "-9223372036854775808";
      2: return "9223372036854775808";
      3: return $sformatf("-%0d", $urandom_range(0, 50));
      4: return "1x";
      5: return "";
      default: return $sformatf("%0d", $urandom_range(0, 999));
    endcase
  endfunction

  // Build one random element, nesting aggregates with children up to four levels deep.
  task automatic build_element(int depth);
    int pick, n, kids;
    logic [7:0] k;
    pick = $urandom_range(0, 14);
    case (pick)
      0: k = K_SIMPLE;
      1: k = K_ERROR;
      2: k = K_INT;
      3: k = K_BULK;
      4: k = K_NULL;
      5: k = K_BOOL;
      6: k = K_DOUBLE;
      7: k = K_BIGNUM;
      8: k = K_BLOBER;
      9: k = K_VERBAT;
      10: k = K_ARRAY;
      11: k = K_MAP;
      12: k = K_SET;
      13: k = K_PUSH;
      default: k = K_ATTR;
    endcase
    frame_bytes.push_back(k);
    case (k)
      K_SIMPLE, K_ERROR: begin
        n = $urandom_range(0, 5);
        repeat (n) frame_bytes.push_back(($urandom_range(0, 15) == 0) ? CH_CR :
                                         8'($urandom_range(32, 126)));
        add_text("^");
      end
      K_INT: add_text({int_text(), "^"});
      K_BULK, K_BLOBER, K_VERBAT: begin
        if ($urandom_range(0, 7) == 0) begin
          add_text({int_text(), "^"});
        end else begin
          n = $urandom_range(0, 8);
          add_text($sformatf("%0d^", n));
          repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
          add_text("^");
        end
      end
      K_NULL: add_text("^");
      K_BOOL: add_text(($urandom_range(0, 1) != 0) ? "t^" : "f^");
      K_DOUBLE: begin
        case ($urandom_range(0, 6))
          0: add_text("inf^");
          1: add_text("-inf^");
          2: add_text("nan^");
          3: add_text("1.5e-3^");
          4: add_text("+.25E7^");
          5: add_text("1e^");
          default: add_text($sformatf("%0d.%0d^", $urandom_range(0, 99), $urandom_range(0, 9)));
        endcase
      end
      K_BIGNUM: add_text({($urandom_range(0, 1) != 0) ? "-" : "",
                          $sformatf("%0d%0d^", $urandom, $urandom)});
      default: begin
        if (k == K_ARRAY && $urandom_range(0, 9) == 0) begin
          add_text("-1^");
        end else begin
          kids = (depth < 4) ? $urandom_range(0, 3) : 0;
          add_text($sformatf("%0d^", kids));
          if (k == K_MAP || k == K_ATTR) kids = kids * 2;
          repeat (kids) build_element(depth + 1);
        end
      end
    endcase
  endtask

  // Fill about nwords of stimulus: mostly valid frames, some damaged, some junk.
  task automatic make_frames(int nwords);
    int target;
    target = pending_words.size() + nwords;
    while (pending_words.size() < target) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_element(0);
        if ($urandom_range(0, 9) == 0)
          frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
      queue_frame(70);
    end
  endtask

  // Write one register, then drop cfg_we before returning so back-to-back writes never collide.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MAX_PAYLOAD) lim_payload = val;
    else if (idx == CFG_MAX_NESTING) lim_nest = val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every word is taken and every verdict is back, then let it settle.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || verdicts_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] pay, logic [3:0] nest, int nwords, int long_hold);
    drain();
    write_reg(CFG_MAX_PAYLOAD, pay);
    write_reg(CFG_MAX_NESTING, nest);
    make_frames(nwords);
    if (long_hold != 0) hold_reqs <= hold_reqs + 1;
  endtask

  initial begin
    string directed[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = 8'd0;
    in_buffer_end = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_PAYLOAD;
    cfg_wdata = 32'd0;
    lim_payload = MAX_PAYLOAD_RST;
    lim_nest = MAX_NESTING_RST;
    ph = P_TYPE;
    lvl = 0;
    held_err = ST_OK;
    cr_held = 1'b0;
    bulk_cr_ok = 1'b0;
    seen = 64'd0;
    top_k = 8'd0;
    top_cnt = 64'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at reset settings: every type, null forms, integer
    // extremes, bad terminators, held unknown type, lone CR in a header.
    idle_in_pct = 6;
    idle_out_pct = 57;
    directed = '{"+OK^", "-ERR x^", ":-9223372036854775808^", ":9223372036854775807^",
                 ":9223372036854775808^", ":12a^", "$3^a^b^", "$-1^", "$-2^", "*-1^",
                 "*2^:1^#t^", "%1^+a^,inf^", "_^", "#x^", ",-1.5e+3^", ",.^", "(-123^",
                 "!0^^", "=2^abXY", "|1^+a^:1^", "~0^", "Q^", "+a\x0db^", "*-2^",
                 ">1^$1^z^"};
    foreach (directed[i]) begin
      add_text(directed[i]);
      queue_frame(100);
    end
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h00);
    queue_frame(100);
    make_frames(150);

    run_phase(32'hFFFF_FFFF, 4'd15, 200, 0);
    idle_in_pct = 57;
    idle_out_pct = 6;
    run_phase(32'd0, 4'd0, 60, 0);
    run_phase(32'd6, 4'd2, 200, 0);
    idle_in_pct = 0;
    idle_out_pct = 0;
    drain();
    write_reg(CFG_UNUSED, 32'd3);
    run_phase(32'd40, 4'd1, 200, 0);
    run_phase(32'd1000, 4'd8, 150, 1);
    drain();

    if (errors == 0) begin
      $display("resp3_frame_validator_top: match");
    end else begin
      $display("resp3_frame_validator_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
